### design/psl_pkg.sv
// ----------------------------------------------------------------------------
// psl_pkg
// shared types, sizes and codes of the per-source connection limiter
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int SlotCount  = 1024;
  localparam int IndexBits  = 16;
  localparam int SlotBits   = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int SrcEntries = 1 << IndexBits;
  localparam int ClrLen     = (SrcEntries > SlotCount) ? SrcEntries : SlotCount;
  localparam int ClrBits    = $clog2(ClrLen);
  localparam int CountBits  = 16;
  localparam int OpenBits   = 11;
  localparam int IdBits     = 32;
  localparam int CfgBits    = 16;

  localparam logic [CountBits-1:0] SrcLimitRst = CountBits'(10);
  localparam logic [OpenBits-1:0]  GlbLimitRst = OpenBits'(1000);

  localparam logic ActOpen  = 1'b0;
  localparam logic ActClose = 1'b1;

  localparam logic CfgSourceLimit = 1'b0;
  localparam logic CfgGlobalLimit = 1'b1;

  typedef enum logic [2:0] {
    StAdmitted    = 3'd0,
    StSrcLimit    = 3'd1,
    StGlobalLimit = 3'd2,
    StNoSlot      = 3'd3,
    StClosed      = 3'd4,
    StNotFound    = 3'd5
  } status_e;

  typedef struct packed {
    logic              action;
    logic [31:0]       src_addr;
    logic [IdBits-1:0] close_id;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [IdBits-1:0] assigned_id;
  } rsp_t;

  typedef struct packed {
    logic                 used;
    logic [IndexBits-1:0] src;
    logic [IdBits-1:0]    conn_id;
  } slot_t;

endpackage

### design/psl_ram.sv
// ----------------------------------------------------------------------------
// psl_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module psl_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/per_source_connection_limiter.sv
// ----------------------------------------------------------------------------
// per_source_connection_limiter
// admits or releases connections against a per-source and a global limit
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid_i / in_ready_o   in_req_i   (action, src_addr, close_id)
//  out       out_valid_o / out_ready_i out_rsp_o  (status, assigned_id)
//  cfg       cfg_we_i                  cfg_idx_i, cfg_data_i
//
//  one transaction at a time; the slot ram is scanned one entry per cycle
//  open: limit check first, then a scan for the lowest free slot
//  close: a scan for the matching slot; not found after the last slot
//  after reset a clearing pass over every entry of both rams runs first
//  a finished result waits in the output register while the next one is taken
// ----------------------------------------------------------------------------
module per_source_connection_limiter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [psl_pkg::CfgBits-1:0]       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  psl_pkg::req_t                     in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output psl_pkg::rsp_t                     out_rsp_o
);
  import psl_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SRC   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CLCNT = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  localparam logic [SlotBits-1:0] SlotLast = SlotBits'(SlotCount - 1);
  localparam logic [ClrBits-1:0]  ClrLast  = ClrBits'(ClrLen - 1);

  logic [2:0]           state_q, state_d;
  logic [ClrBits-1:0]   clr_q, clr_d;
  logic [CountBits-1:0] src_lim_q, src_lim_d;
  logic [OpenBits-1:0]  glb_lim_q, glb_lim_d;
  logic [OpenBits-1:0]  open_total_q, open_total_d;
  logic [IdBits-1:0]    id_ctr_q, id_ctr_d;
  logic                 issue_q, issue_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 out_valid_q, out_valid_d;

  req_t                 req_q, req_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [IndexBits-1:0] src_idx_q, src_idx_d;
  logic [SlotBits-1:0]  scan_q, scan_d;
  logic [SlotBits-1:0]  chk_idx_q, chk_idx_d;
  rsp_t                 res_q, res_d;
  rsp_t                 out_q, out_d;

  logic                 src_we;
  logic [IndexBits-1:0] src_waddr, src_raddr;
  logic [CountBits-1:0] src_wdata, src_rdata;
  logic                 slot_we;
  logic [SlotBits-1:0]  slot_waddr, slot_raddr;
  slot_t                slot_wdata, slot_rdata;
  logic                 hit;

  psl_ram #(.Width(CountBits), .Depth(SrcEntries)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (src_raddr),
    .rdata_o (src_rdata)
  );

  psl_ram #(.Width($bits(slot_t)), .Depth(SlotCount)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    src_lim_d    = src_lim_q;
    glb_lim_d    = glb_lim_q;
    open_total_d = open_total_q;
    id_ctr_d     = id_ctr_q;
    issue_d      = issue_q;
    chk_vld_d    = chk_vld_q;
    out_valid_d  = out_valid_q;
    req_d        = req_q;
    cnt_d        = cnt_q;
    src_idx_d    = src_idx_q;
    scan_d       = scan_q;
    chk_idx_d    = chk_idx_q;
    res_d        = res_q;
    out_d        = out_q;
    src_we       = 1'b0;
    src_waddr    = src_idx_q;
    src_wdata    = '0;
    src_raddr    = src_idx_q;
    slot_we      = 1'b0;
    slot_waddr   = chk_idx_q;
    slot_wdata   = '0;
    slot_raddr   = scan_q;
    hit          = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSourceLimit: src_lim_d = cfg_data_i;
        CfgGlobalLimit: glb_lim_d = cfg_data_i[OpenBits-1:0];
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        src_we     = ({1'b0, clr_q} < (ClrBits + 1)'(SrcEntries));
        src_waddr  = clr_q[IndexBits-1:0];
        slot_we    = ({1'b0, clr_q} < (ClrBits + 1)'(SlotCount));
        slot_waddr = clr_q[SlotBits-1:0];
        if (clr_q == ClrLast) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        src_raddr = in_req_i.src_addr[IndexBits-1:0];
        if (in_valid_i) begin
          req_d     = in_req_i;
          src_idx_d = in_req_i.src_addr[IndexBits-1:0];
          if (in_req_i.action == ActOpen) begin
            state_d = S_SRC;
          end else begin
            scan_d    = '0;
            issue_d   = 1'b1;
            chk_vld_d = 1'b0;
            state_d   = S_SCAN;
          end
        end
      end
      S_SRC: begin
        cnt_d = src_rdata;
        priority if (src_rdata > src_lim_q) begin
          res_d   = '{status: StSrcLimit, assigned_id: '0};
          state_d = S_RESP;
        end else if (open_total_q >= glb_lim_q) begin
          res_d   = '{status: StGlobalLimit, assigned_id: '0};
          state_d = S_RESP;
        end else begin
          scan_d    = '0;
          issue_d   = 1'b1;
          chk_vld_d = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_q) begin
          chk_idx_d = scan_q;
          chk_vld_d = 1'b1;
          if (scan_q == SlotLast) begin
            issue_d = 1'b0;
          end else begin
            scan_d = scan_q + 1'b1;
          end
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if (req_q.action == ActOpen) begin
            hit = !slot_rdata.used;
          end else begin
            hit = slot_rdata.used && (slot_rdata.conn_id == req_q.close_id);
          end
          if (hit) begin
            issue_d   = 1'b0;
            chk_vld_d = 1'b0;
            slot_we   = 1'b1;
            if (req_q.action == ActOpen) begin
              slot_wdata   = '{used: 1'b1, src: src_idx_q, conn_id: id_ctr_q + 1'b1};
              src_we       = 1'b1;
              src_wdata    = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
              open_total_d = open_total_q + 1'b1;
              id_ctr_d     = id_ctr_q + 1'b1;
              res_d        = '{status: StAdmitted, assigned_id: id_ctr_q + 1'b1};
              state_d      = S_RESP;
            end else begin
              slot_wdata = '{used: 1'b0, src: slot_rdata.src, conn_id: slot_rdata.conn_id};
              src_raddr  = slot_rdata.src;
              src_idx_d  = slot_rdata.src;
              state_d    = S_CLCNT;
            end
          end else if (chk_idx_q == SlotLast) begin
            issue_d   = 1'b0;
            chk_vld_d = 1'b0;
            if (req_q.action == ActOpen) begin
              res_d = '{status: StNoSlot, assigned_id: '0};
            end else begin
              res_d = '{status: StNotFound, assigned_id: '0};
            end
            state_d = S_RESP;
          end
        end
      end
      S_CLCNT: begin
        src_we    = 1'b1;
        src_wdata = (src_rdata != '0) ? src_rdata - 1'b1 : src_rdata;
        if (open_total_q != '0) begin
          open_total_d = open_total_q - 1'b1;
        end
        res_d   = '{status: StClosed, assigned_id: '0};
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      src_lim_q    <= SrcLimitRst;
      glb_lim_q    <= GlbLimitRst;
      open_total_q <= '0;
      id_ctr_q     <= '0;
      issue_q      <= 1'b0;
      chk_vld_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      src_lim_q    <= src_lim_d;
      glb_lim_q    <= glb_lim_d;
      open_total_q <= open_total_d;
      id_ctr_q     <= id_ctr_d;
      issue_q      <= issue_d;
      chk_vld_q    <= chk_vld_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    cnt_q     <= cnt_d;
    src_idx_q <= src_idx_d;
    scan_q    <= scan_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

endmodule

### sim/conn_limit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conn_limit_checker
// watches the limiter's channels, predicts every admission or release result
// from the accepted requests and register writes, and compares field by field
// ----------------------------------------------------------------------------
module conn_limit_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [psl_pkg::CfgBits-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  psl_pkg::req_t               in_req_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  psl_pkg::rsp_t               out_rsp_i,
  output int                          err_count_o,
  output int                          pending_o
);
  import psl_pkg::*;

  localparam logic [CountBits-1:0] CountMax = '1;

  logic [CountBits-1:0] src_limit;
  logic [OpenBits-1:0]  glb_limit;
  logic [CountBits-1:0] src_count [SrcEntries];
  slot_t                slot_tab [SlotCount];
  logic [OpenBits-1:0]  open_total;
  logic [IdBits-1:0]    id_counter;
  rsp_t                 result_q [$];
  rsp_t                 want_rsp;

  function automatic void clear_tables();
    src_limit  = SrcLimitRst;
    glb_limit  = GlbLimitRst;
    open_total = '0;
    id_counter = '0;
    for (int i = 0; i < SrcEntries; i++) begin
      src_count[i] = '0;
    end
    for (int s = 0; s < SlotCount; s++) begin
      slot_tab[s] = '0;
    end
  endfunction

  function automatic rsp_t predict_admission(req_t req);
    rsp_t                 rsp;
    logic [IndexBits-1:0] idx;
    bit                   done;
    rsp.status      = StNotFound;
    rsp.assigned_id = '0;
    done            = 1'b0;
    if (req.action == ActOpen) begin
      idx = req.src_addr[IndexBits-1:0];
      if (src_count[idx] > src_limit) begin
        rsp.status = StSrcLimit;
      end else if (open_total >= glb_limit) begin
        rsp.status = StGlobalLimit;
      end else begin
        rsp.status = StNoSlot;
        for (int s = 0; s < SlotCount && !done; s++) begin
          if (!slot_tab[s].used) begin
            id_counter  = id_counter + 1'b1;
            slot_tab[s] = '{used: 1'b1, src: idx, conn_id: id_counter};
            open_total  = open_total + 1'b1;
            if (src_count[idx] != CountMax) begin
              src_count[idx] = src_count[idx] + 1'b1;
            end
            rsp.status      = StAdmitted;
            rsp.assigned_id = id_counter;
            done            = 1'b1;
          end
        end
      end
    end else begin
      for (int s = 0; s < SlotCount && !done; s++) begin
        if (slot_tab[s].used && slot_tab[s].conn_id == req.close_id) begin
          slot_tab[s].used = 1'b0;
          if (open_total != '0) begin
            open_total = open_total - 1'b1;
          end
          if (src_count[slot_tab[s].src] != '0) begin
            src_count[slot_tab[s].src] = src_count[slot_tab[s].src] - 1'b1;
          end
          rsp.status = StClosed;
          done       = 1'b1;
        end
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [IdBits-1:0] got,
                                 logic [IdBits-1:0] want);
    $display("%0t ns mismatch on %s: got %0h, want %0h", $time, what, got, want);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tables();
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSourceLimit) begin
          src_limit = cfg_data_i[CountBits-1:0];
        end else begin
          glb_limit = cfg_data_i[OpenBits-1:0];
        end
      end
      if (in_valid_i && in_ready_i) begin
        result_q.push_back(predict_admission(in_req_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("transaction with nothing outstanding",
                          out_rsp_i.assigned_id, '0);
        end else begin
          want_rsp = result_q.pop_front();
          if (out_rsp_i.status !== want_rsp.status) begin
            report_mismatch("status", IdBits'(out_rsp_i.status), IdBits'(want_rsp.status));
          end
          if (out_rsp_i.assigned_id !== want_rsp.assigned_id) begin
            report_mismatch("assigned_id", out_rsp_i.assigned_id, want_rsp.assigned_id);
          end
        end
      end
    end
    pending_o = result_q.size();
  end

endmodule

### sim/per_source_connection_limiter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_source_connection_limiter_tb
// drives open and close requests in bursts through the limiter under several
// limit settings, fills the slot table, and stalls the result side at random
// ----------------------------------------------------------------------------
module per_source_connection_limiter_tb;
  import psl_pkg::*;

  localparam int WatchdogLimit = 250000;
  localparam int HoldOffCycles = 400;

  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyQuarter,
    ReadyMostly
  } ready_mode_e;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [CfgBits-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  req_t               in_req_i;
  logic               out_valid_o;
  logic               out_ready_i;
  rsp_t               out_rsp_o;
  int                 err_count;
  int                 pending;

  bit                 hold_off_req;
  int                 burst_left;
  int                 idle_cycles;
  logic [IdBits-1:0]  live_ids [$];
  logic [IdBits-1:0]  retired_ids [$];

  per_source_connection_limiter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  conn_limit_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_i  (out_rsp_o),
    .err_count_o(err_count),
    .pending_o  (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ids handed out, kept for closes
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i && out_rsp_o.status == StAdmitted) begin
      live_ids.push_back(out_rsp_o.assigned_id);
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          cyc;
    ready_mode_e mode;
    cyc         = 0;
    mode        = ReadyAlways;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 128 == 0) begin
        mode = ready_mode_e'($urandom_range(0, 3));
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk_i);
      end else begin
        case (mode)
          ReadyAlways:  out_ready_i <= 1'b1;
          ReadyCoin:    out_ready_i <= 1'($urandom_range(0, 1));
          ReadyQuarter: out_ready_i <= (cyc % 4 == 0);
          default:      out_ready_i <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic req_t open_item(logic [31:0] addr);
    req_t r;
    r.action   = ActOpen;
    r.src_addr = addr;
    r.close_id = $urandom;
    return r;
  endfunction

  function automatic req_t close_item(logic [IdBits-1:0] id);
    req_t r;
    r.action   = ActClose;
    r.src_addr = $urandom;
    r.close_id = id;
    return r;
  endfunction

  function automatic logic [IdBits-1:0] take_live_id();
    int                k;
    logic [IdBits-1:0] id;
    k  = $urandom_range(0, live_ids.size() - 1);
    id = live_ids[k];
    live_ids.delete(k);
    retired_ids.push_back(id);
    return id;
  endfunction

  task automatic send_req(req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [CfgBits-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_random(int n);
    int          pick;
    logic [15:0] low;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 || (live_ids.size() == 0 && pick < 90)) begin
        case ($urandom_range(0, 5))
          0:       low = 16'h0000;
          1:       low = 16'hFFFF;
          2:       low = 16'h1234;
          3:       low = 16'h8001;
          4:       low = 16'h00FF;
          default: low = 16'($urandom);
        endcase
        send_req(open_item({16'($urandom), low}));
      end else if (pick < 90) begin
        send_req(close_item(take_live_id()));
      end else if (pick < 95 && retired_ids.size() != 0) begin
        send_req(close_item(retired_ids[$urandom_range(0, retired_ids.size() - 1)]));
      end else begin
        send_req(close_item($urandom));
      end
    end
  endtask

  initial begin
    int fill_n;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgSourceLimit;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset limits: address extremes, closes, one source run past its limit
    send_req(open_item(32'h0000_0000));
    send_req(open_item(32'hFFFF_FFFF));
    send_req(close_item(32'd1));
    send_req(close_item(32'd1));
    send_req(close_item(32'd2));
    send_req(close_item('1));
    send_req(close_item('0));
    repeat (12) send_req(open_item({16'($urandom), 16'h1234}));
    drain();
    void'(live_ids.pop_front());
    void'(live_ids.pop_front());

    // zero limits
    write_reg(CfgSourceLimit, 16'd0);
    write_reg(CfgGlobalLimit, 16'd0);
    send_req(open_item(32'h0000_5678));
    send_req(open_item(32'h7777_1234));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(CfgSourceLimit, 16'd3);
          write_reg(CfgGlobalLimit, 16'd40);
        end
        1: begin
          write_reg(CfgSourceLimit, 16'd65534);
          write_reg(CfgGlobalLimit, 16'(SlotCount));
          hold_off_req = 1'b1;
        end
        2: begin
          write_reg(CfgSourceLimit, 16'd0);
          write_reg(CfgGlobalLimit, 16'd1);
        end
        3: begin
          write_reg(CfgSourceLimit, 16'hFFFF);
          write_reg(CfgGlobalLimit, 16'd20);
        end
        4: begin
          write_reg(CfgSourceLimit, 16'd2);
          write_reg(CfgGlobalLimit, 16'd2047);
        end
        default: begin
          write_reg(CfgSourceLimit, 16'($urandom_range(0, 12)));
          write_reg(CfgGlobalLimit, 16'($urandom_range(1, 64)));
        end
      endcase
      send_random(72);
      drain();
    end

    // table full with the global limit above the slot count
    write_reg(CfgSourceLimit, 16'hFFFF);
    write_reg(CfgGlobalLimit, 16'd2047);
    fill_n = SlotCount - live_ids.size() + 3;
    repeat (fill_n) send_req(open_item($urandom));
    drain();
    send_req(close_item(take_live_id()));
    send_req(open_item($urandom));
    send_req(open_item($urandom));
    send_req(close_item(32'hDEAD_BEEF));
    drain();
    write_reg(CfgGlobalLimit, 16'(SlotCount));
    send_req(open_item($urandom));
    drain();

    repeat (20) @(negedge clk_i);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
